// File: src/csp_pkg.sv
package csp_pkg;

    // Position in the color specification grammar.
    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_HASH   = 3'd1,
        PH_PREFIX = 3'd2,
        PH_RED    = 3'd3,
        PH_GREEN  = 3'd4,
        PH_BLUE   = 3'd5
    } t_phase;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic        valid_res;
        logic [23:0] color;
    } t_out_word;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LOW_R = 8'h72;
    localparam logic [7:0] CH_LOW_G = 8'h67;
    localparam logic [7:0] CH_LOW_B = 8'h62;

    localparam logic [2:0] HASH_DIGITS = 3'd6;
    localparam logic [2:0] COMP_DIGITS = 3'd4;
    localparam logic [7:0] ONE_DIGIT_SCALE = 8'h11;

endpackage

// File: src/color_spec_parser_unit.sv
// The input channel carries one word per character of a color specification:
// an ASCII byte and a flag that marks the final character. Two forms parse:
// '#' with exactly six hex digits, and "rgb:" with three slash-separated
// components of one to four hex digits each. Every other text is rejected.
//
// The output channel carries one word for each specification, and only on
// its final character: a valid flag and the 24-bit color (red in the top
// byte). A rejected specification gives valid_res low and color zero.
//
// Throughput is one character per cycle while the output is not stalled.
// A word accepted into the input register is parsed into the output
// register once that register can take a new value. The input and output
// registers form a two-deep pipeline; the only loop is the running parse
// state, which is updated once for each parsed character.
//
// A synchronous low reset empties both registers and returns the parser to
// the start of a specification. While the receiver stalls a shown result,
// that result holds, one more character can still be taken into the input
// register, and then the input channel stalls as well.
module color_spec_parser_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  csp_pkg::t_in_word   i_in_word,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output csp_pkg::t_out_word  o_out_word,
    input  logic                i_out_stall
);

    // Scale a component of one to four digits down to eight bits.
    function automatic logic [7:0] scale_comp(input logic [15:0] v, input logic [2:0] n);
        logic [7:0] res;
        case (n)
            3'd1:    res = v[7:0] * csp_pkg::ONE_DIGIT_SCALE;
            3'd2:    res = v[7:0];
            3'd3:    res = v[11:4];
            default: res = v[15:8];
        endcase
        return res;
    endfunction

    // Input register.
    logic               r_in_valid;
    csp_pkg::t_in_word  r_in;

    // Running parse state.
    csp_pkg::t_phase    r_phase, n_phase;
    logic [2:0]         r_count, n_count;
    logic [23:0]        r_accum, n_accum;
    logic [7:0]         r_red, n_red;
    logic [7:0]         r_green, n_green;
    logic               r_failed, n_failed;

    // Output register.
    logic               r_out_valid;
    csp_pkg::t_out_word r_out, n_out;

    logic advance;      // the output register can take a new value
    logic load;         // the input register can take a new word
    logic process;      // the held character is parsed this cycle
    logic hex_ok;
    logic [3:0] hex_val;

    assign advance     = !r_out_valid || !i_out_stall;
    assign load        = !r_in_valid || advance;
    assign process     = r_in_valid && advance;
    assign o_in_stall  = !load;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Hex digit decode, either case.
    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (r_in.ch >= 8'h30 && r_in.ch <= 8'h39) begin
            hex_val = 4'(r_in.ch - 8'h30);
        end else if (r_in.ch >= 8'h61 && r_in.ch <= 8'h66) begin
            hex_val = 4'(r_in.ch - 8'h57);
        end else if (r_in.ch >= 8'h41 && r_in.ch <= 8'h46) begin
            hex_val = 4'(r_in.ch - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_accum  = r_accum;
        n_red    = r_red;
        n_green  = r_green;
        n_failed = r_failed;
        n_out    = r_out;

        if (process) begin
            if (!r_failed) begin
                unique case (r_phase)
                    csp_pkg::PH_START: begin
                        if (r_in.ch == csp_pkg::CH_HASH) begin
                            n_phase = csp_pkg::PH_HASH;
                            n_count = 3'd0;
                            n_accum = 24'd0;
                        end else if (r_in.ch == csp_pkg::CH_LOW_R) begin
                            n_phase = csp_pkg::PH_PREFIX;
                            n_count = 3'd1;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    csp_pkg::PH_HASH: begin
                        if (hex_ok && r_count < csp_pkg::HASH_DIGITS) begin
                            n_accum = {r_accum[19:0], hex_val};
                            n_count = r_count + 3'd1;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    csp_pkg::PH_PREFIX: begin
                        if (r_count == 3'd1 && r_in.ch == csp_pkg::CH_LOW_G) begin
                            n_count = 3'd2;
                        end else if (r_count == 3'd2 && r_in.ch == csp_pkg::CH_LOW_B) begin
                            n_count = 3'd3;
                        end else if (r_count == 3'd3 && r_in.ch == csp_pkg::CH_COLON) begin
                            n_phase = csp_pkg::PH_RED;
                            n_count = 3'd0;
                            n_accum = 24'd0;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    csp_pkg::PH_RED, csp_pkg::PH_GREEN, csp_pkg::PH_BLUE: begin
                        if (r_in.ch == csp_pkg::CH_SLASH && r_phase != csp_pkg::PH_BLUE) begin
                            if (r_count == 3'd0 || r_count > csp_pkg::COMP_DIGITS) begin
                                n_failed = 1'b1;
                            end else begin
                                if (r_phase == csp_pkg::PH_RED) begin
                                    n_red   = scale_comp(r_accum[15:0], r_count);
                                    n_phase = csp_pkg::PH_GREEN;
                                end else begin
                                    n_green = scale_comp(r_accum[15:0], r_count);
                                    n_phase = csp_pkg::PH_BLUE;
                                end
                                n_count = 3'd0;
                                n_accum = 24'd0;
                            end
                        end else if (hex_ok && r_count < csp_pkg::COMP_DIGITS) begin
                            n_accum = {8'd0, r_accum[11:0], hex_val};
                            n_count = r_count + 3'd1;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    default: begin
                        n_failed = 1'b1;
                    end
                endcase
            end

            // The final character closes the specification and clears the state.
            if (r_in.last) begin
                n_out.valid_res = 1'b0;
                n_out.color     = 24'd0;
                if (!n_failed) begin
                    if (n_phase == csp_pkg::PH_HASH && n_count == csp_pkg::HASH_DIGITS) begin
                        n_out.valid_res = 1'b1;
                        n_out.color     = n_accum;
                    end else if (n_phase == csp_pkg::PH_BLUE && n_count != 3'd0
                                 && n_count <= csp_pkg::COMP_DIGITS) begin
                        n_out.valid_res = 1'b1;
                        n_out.color     = {n_red, n_green,
                                           scale_comp(n_accum[15:0], n_count)};
                    end
                end
                n_phase  = csp_pkg::PH_START;
                n_count  = 3'd0;
                n_accum  = 24'd0;
                n_red    = 8'd0;
                n_green  = 8'd0;
                n_failed = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= csp_pkg::PH_START;
            r_count     <= 3'd0;
            r_accum     <= 24'd0;
            r_red       <= 8'd0;
            r_green     <= 8'd0;
            r_failed    <= 1'b0;
        end else begin
            if (load) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= process && r_in.last;
            end
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_accum  <= n_accum;
            r_red    <= n_red;
            r_green  <= n_green;
            r_failed <= n_failed;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (load && i_in_valid) begin
            r_in <= i_in_word;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

// File: src/csp_checker.sv
module csp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input csp_pkg::t_in_word   i_in_word,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input csp_pkg::t_out_word  o_out_word,
    input logic                i_out_stall
);

    // A stalled result word holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed");

    // A rejected specification carries a zero color.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.valid_res |-> o_out_word.color == 24'd0)
        else $error("rejected result with nonzero color");

    // The input side stalls only behind a stalled result word.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back pressure");

    // A final character that is taken leads to a shown result word.
    a_last_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_word.last |=> ##1 o_out_valid)
        else $error("final character gave no result word");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word shown after reset");

endmodule

bind color_spec_parser_unit csp_checker u_csp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_word   (i_in_word),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_word  (o_out_word),
    .i_out_stall (i_out_stall)
);
